// File: rtl/core/ftsd_pkg.sv
package ftsd_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_ROUND,
		ST_FLT,
		ST_PLACE,
		ST_STRIP,
		ST_DONE
	} ftsd_state_t;

	localparam logic [7:0]  EXP_SPECIAL  = 8'hFF;
	localparam int          EXP_BIAS     = 127;
	localparam int          EXP_LOW      = -94;
	localparam int          EXP_HIGH     = 96;
	// binary exponent below which the magnitude is still below 2^21
	localparam int          STOP_EXP     = 21;
	localparam int          DBL_FRAC     = 52;
	localparam int          SGL_FRAC     = 23;
	// reciprocal of ten, used with a right shift of 35
	localparam logic [31:0] RECIP_TEN    = 32'hCCCCCCCD;
	localparam int          RECIP_SHIFT  = 35;

endpackage

// File: rtl/core/float_to_scaled_decimal_core.sv
// Channel | Direction | Payload
// s_axis  | in        | tdata[31:0] float_bits
// m_axis  | out       | tdata[95:0] coefficient, [100:96] scale, [101] negative; tuser error
//
// One item at a time: the item is accepted, then takes up to MAX_SCALE multiply-by-ten steps on
// the 53-bit shift-add unit until the stop is seen, is rounded and placed (ROUND, FLT, PLACE),
// takes up to MAX_SCALE divide-by-ten steps on the reciprocal multiplier until a nonzero
// remainder is seen, then the result is held until taken.
// Special inputs (zero, infinity, NaN, exponent out of range) go straight to the result.
// s_tready is high only while the block is idle; a stalled result holds all registers.
// Reset (arst_n low) returns the sequencer to idle and drops m_tvalid.
module float_to_scaled_decimal_core
	import ftsd_pkg::*;
#(
	parameter int MAX_SCALE = 28
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] float_bits
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // [31:0] coef_low, [63:32] coef_mid, [95:64] coef_high,
	                                // [100:96] scale, [101] negative, [103:102] zero
	output logic         m_tuser    // [0] error
);

	ftsd_state_t state_q, state_d;

	logic [53:0]       mant_q;
	logic signed [9:0] ue_q;
	logic [4:0]        scl_q;
	logic              neg_q;
	logic              err_q;
	logic              zero_q;
	logic [6:0]        sh_q;
	logic [5:0]        lead_q;
	logic [23:0]       m24_q;
	logic [7:0]        me_q;
	logic [95:0]       coef_q;

	// input decode
	logic [7:0]        in_exp;
	logic signed [9:0] in_e;
	logic              in_special;
	logic              in_zero;
	assign in_exp     = s_tdata[30:23];
	assign in_e       = $signed({2'b00, in_exp}) - 10'sd127;
	assign in_special = (in_exp == EXP_SPECIAL);
	assign in_zero    = (s_tdata[30:0] == 31'd0) || (in_e <= 10'(EXP_LOW))
	                    || (in_e >= 10'(EXP_HIGH));

	// multiply-by-ten with round to nearest even
	logic [56:0] p10;
	logic [52:0] p_keep;
	logic        p_guard, p_sticky, p_up;
	logic [53:0] p_sum;
	logic        scale_go;
	always_comb begin
		p10 = {1'b0, mant_q[52:0], 3'd0} + {3'd0, mant_q[52:0], 1'b0};
		if (p10[56]) begin
			p_keep   = p10[56:4];
			p_guard  = p10[3];
			p_sticky = |p10[2:0];
		end else begin
			p_keep   = p10[55:3];
			p_guard  = p10[2];
			p_sticky = |p10[1:0];
		end
		p_up  = p_guard & (p_sticky | p_keep[0]);
		p_sum = {1'b0, p_keep} + {53'd0, p_up};
	end
	assign scale_go = (scl_q < 5'(MAX_SCALE)) && (ue_q < 10'sd21);

	// round half away from zero to an integer
	logic [5:0]  rnd_sh;
	logic [53:0] rnd_t, rnd_n;
	logic [5:0]  rnd_idx;
	always_comb begin
		rnd_sh  = 6'(10'sd51 - ue_q);
		rnd_t   = mant_q >> rnd_sh;
		rnd_n   = (rnd_t + 54'd1) >> 1;
		rnd_idx = 6'(ue_q + 10'sd1);
	end

	// integer to single, round to nearest even
	logic [5:0]  f_d;
	logic [53:0] f_kept;
	logic        f_guard, f_sticky;
	logic [24:0] f_sum;
	always_comb begin
		f_d      = lead_q - 6'd23;
		f_kept   = mant_q >> f_d;
		f_guard  = mant_q[6'(f_d - 6'd1)];
		f_sticky = |(mant_q & ((54'd1 << 6'(f_d - 6'd1)) - 54'd1));
		f_sum    = {1'b0, f_kept[23:0]} + {24'd0, f_guard & (f_sticky | f_kept[0])};
	end

	// divide by ten through the reciprocal
	logic [63:0] dv_prod;
	logic [31:0] dv_q, dv_r;
	always_comb begin
		dv_prod = 64'(coef_q[31:0]) * 64'(RECIP_TEN);
		dv_q    = 32'(dv_prod >> RECIP_SHIFT);
		dv_r    = coef_q[31:0] - {dv_q[28:0], 3'd0} - {dv_q[30:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid)
					state_d = (in_special || in_zero) ? ST_DONE : ST_SCALE;
			end
			ST_SCALE: begin
				if (!scale_go)
					state_d = ST_ROUND;
			end
			ST_ROUND: begin
				state_d = (ue_q < -10'sd1) ? ST_DONE : ST_FLT;
			end
			ST_FLT:   state_d = ST_PLACE;
			ST_PLACE: state_d = (scl_q != 5'd0) ? ST_STRIP : ST_DONE;
			ST_STRIP: begin
				if (scl_q == 5'd0 || dv_r != 32'd0)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (m_tready)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mant_q <= {2'b01, s_tdata[22:0], 29'd0};
				ue_q   <= in_e;
				scl_q  <= 5'd0;
				neg_q  <= s_tdata[31];
				err_q  <= in_special;
				zero_q <= in_special || in_zero;
				coef_q <= '0;
			end
			ST_SCALE: begin
				if (scale_go) begin
					scl_q <= scl_q + 5'd1;
					if (p_sum[53]) begin
						mant_q <= {2'b01, 52'd0};
						ue_q   <= ue_q + (p10[56] ? 10'sd5 : 10'sd4);
					end else begin
						mant_q <= p_sum;
						ue_q   <= ue_q + (p10[56] ? 10'sd4 : 10'sd3);
					end
				end
			end
			ST_ROUND: begin
				if (ue_q >= 10'sd52) begin
					lead_q <= 6'd52;
					sh_q   <= 7'(ue_q - 10'sd52);
				end else if (ue_q < -10'sd1) begin
					zero_q <= 1'b1;
				end else begin
					mant_q <= rnd_n;
					lead_q <= rnd_n[rnd_idx] ? rnd_idx : 6'(ue_q);
					sh_q   <= 7'd0;
				end
			end
			ST_FLT: begin
				if (lead_q <= 6'd23) begin
					m24_q <= 24'(mant_q << (6'd23 - lead_q));
					me_q  <= {2'b00, lead_q} + {1'b0, sh_q};
				end else if (f_sum[24]) begin
					m24_q <= 24'h800000;
					me_q  <= {2'b00, lead_q} + {1'b0, sh_q} + 8'd1;
				end else begin
					m24_q <= f_sum[23:0];
					me_q  <= {2'b00, lead_q} + {1'b0, sh_q};
				end
			end
			ST_PLACE: begin
				if (me_q >= 8'd23)
					coef_q <= 96'(m24_q) << (me_q - 8'd23);
				else
					coef_q <= 96'(m24_q) >> (8'd23 - me_q);
			end
			ST_STRIP: begin
				if (scl_q != 5'd0 && dv_r == 32'd0) begin
					coef_q <= {64'd0, dv_q};
					scl_q  <= scl_q - 5'd1;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_DONE);
	assign m_tdata  = zero_q ? 104'd0 : {2'b00, neg_q, scl_q, coef_q};
	assign m_tuser  = err_q;

endmodule

// File: rtl/core/ftsd_checker.sv
module ftsd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata,
	input logic         m_tuser
);

	// one item in flight: no new item while a result is waiting
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while result pending");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 104'd0))
		else $error("error result carries data");

	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[100:96] <= 5'd28))
		else $error("scale out of range");

	a_sign_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[101]) |-> (m_tdata[95:0] != 96'd0))
		else $error("negative zero result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind float_to_scaled_decimal_core ftsd_checker u_ftsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
